### sv/mbbe_pkg.sv
package mbbe_pkg;

    // frame store geometry
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam logic [10:0] MAX_SIZE = 11'd1024;

    // item commands
    localparam logic [1:0] CMD_BLIT    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_WRITE   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_DEST_X        = 3'd0;
    localparam logic [2:0] REG_DEST_Y        = 3'd1;
    localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DRAW_COLOR    = 3'd4;

    typedef struct packed {
        logic [10:0] dest_x;
        logic [10:0] dest_y;
        logic [10:0] bitmap_width;
        logic [10:0] bitmap_height;
        logic        draw_color;
    } t_cfg;

    // one classified item: up to two frame byte updates
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr0;
        logic [7:0]        mask0;
        logic [ADDR_W-1:0] addr1;
        logic [7:0]        mask1;
        logic              two;
        logic [7:0]        data;
        logic              color;
        logic              done;
    } t_op;

    typedef struct packed {
        logic [7:0] read_data;
        logic       blit_done;
    } t_res;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [10:0] clamp_size(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (v > MAX_SIZE) begin
            r = MAX_SIZE;
        end
        return r;
    endfunction

endpackage

### sv/mbbe_fifo.sv
module mbbe_fifo #(
    parameter int DEPTH = 4,
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### sv/mbbe_front.sv
module mbbe_front #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbbe_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic [9:0]         i_frame_address,
    input  logic               i_busy,
    output logic               o_op_push,
    output mbbe_pkg::t_op      o_op,
    input  logic               i_op_full
);

    localparam int          BPR   = (FRAME_WIDTH + 7) / 8;
    localparam logic [7:0]  BPR_V = 8'(BPR);
    localparam logic [12:0] FW_V  = 13'(FRAME_WIDTH);
    localparam logic [12:0] FH_V  = 13'(FRAME_HEIGHT);

    logic [6:0]  r_col, n_col;
    logic [9:0]  r_row, n_row;
    logic        n_done;
    logic        accept;
    logic [10:0] w;
    logic [10:0] h;
    logic [7:0]  bw;

    logic        r_s1_valid;
    logic [1:0]  r_s1_cmd;
    logic [7:0]  r_s1_data;
    logic [9:0]  r_s1_addr;
    logic [6:0]  r_s1_col;
    logic [9:0]  r_s1_row;
    logic        r_s1_done;

    logic [12:0] px_base;
    logic [12:0] y;
    logic        y_ok;
    logic [9:0]  b0;
    logic [9:0]  b1;
    logic [7:0]  wmask;
    logic [15:0] win;
    logic [19:0] idx0;
    logic [19:0] idx1;
    logic [7:0]  m0;
    logic [7:0]  m1;

    // pixel columns of frame byte b that lie inside the frame
    function automatic logic [7:0] col_mask(input logic [9:0] b);
        logic [12:0] x;
        logic [7:0]  m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            x    = {b, 3'(7 - j)};
            m[j] = !x[12] && (x < FW_V);
        end
        return m;
    endfunction

    // frame byte index of byte column b on row yr
    function automatic logic [19:0] byte_index(input logic [9:0] b, input logic [10:0] yr);
        return 20'(yr) * 20'(BPR_V) + 20'(b[7:0]);
    endfunction

    assign o_full    = i_busy || (r_s1_valid && i_op_full);
    assign accept    = i_push && !o_full;
    assign o_op_push = r_s1_valid && !i_op_full;

    assign w  = mbbe_pkg::clamp_size(i_cfg.bitmap_width);
    assign h  = mbbe_pkg::clamp_size(i_cfg.bitmap_height);
    assign bw = 8'((12'(w) + 12'd7) >> 3);

    // bitmap position counters
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_done = 1'b0;
        if (accept) begin
            unique case (i_cmd) inside
                mbbe_pkg::CMD_BLIT: begin
                    if (({1'b0, r_col} + 8'd1) >= bw) begin
                        n_col = '0;
                        if (({1'b0, r_row} + 11'd1) >= h) begin
                            n_row  = '0;
                            n_done = 1'b1;
                        end else begin
                            n_row = r_row + 10'd1;
                        end
                    end else begin
                        n_col = r_col + 7'd1;
                    end
                end
                mbbe_pkg::CMD_RESTART: begin
                    n_col = '0;
                    n_row = '0;
                end
                mbbe_pkg::CMD_READ, mbbe_pkg::CMD_WRITE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (!i_op_full) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // item holding stage with its position snapshot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_cmd;
            r_s1_data <= i_data_byte;
            r_s1_addr <= i_frame_address;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_done <= n_done;
        end
    end

    // map the byte onto at most two frame bytes
    always_comb begin
        px_base = 13'({{2{i_cfg.dest_x[10]}}, i_cfg.dest_x}) + {3'b000, r_s1_col, 3'b000};
        y       = 13'({{2{i_cfg.dest_y[10]}}, i_cfg.dest_y}) + {3'b000, r_s1_row};
        y_ok    = !y[12] && (y < FH_V);
        b0      = px_base[12:3];
        b1      = b0 + 10'd1;
        for (int k = 0; k < 8; k++) begin
            wmask[7 - k] = {1'b0, r_s1_col, 3'(k)} < w;
        end
        win  = {r_s1_data & wmask, 8'h00} >> px_base[2:0];
        idx0 = byte_index(b0, y[10:0]);
        idx1 = byte_index(b1, y[10:0]);
        m0   = win[15:8] & col_mask(b0)
             & {8{y_ok && !b0[9] && (idx0[19:10] == '0)}};
        m1   = win[7:0] & col_mask(b1)
             & {8{y_ok && !b1[9] && (idx1[19:10] == '0)}};

        o_op.cmd   = r_s1_cmd;
        o_op.data  = r_s1_data;
        o_op.color = i_cfg.draw_color;
        o_op.done  = r_s1_done;
        o_op.addr1 = idx1[9:0];
        o_op.mask1 = m1;
        if (r_s1_cmd != mbbe_pkg::CMD_BLIT) begin
            o_op.addr0 = r_s1_addr;
            o_op.mask0 = '0;
            o_op.two   = 1'b0;
        end else if (m0 == '0) begin
            o_op.addr0 = idx1[9:0];
            o_op.mask0 = m1;
            o_op.two   = 1'b0;
        end else begin
            o_op.addr0 = idx0[9:0];
            o_op.mask0 = m0;
            o_op.two   = (m1 != '0);
        end
    end

endmodule

### sv/mbbe_back.sv
module mbbe_back #(
    parameter int RES_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbbe_pkg::t_op  i_op,
    input  logic           i_op_empty,
    output logic           o_op_pop,
    output logic           o_res_push,
    output mbbe_pkg::t_res o_res,
    input  logic           i_res_pop,
    output logic           o_busy
);

    localparam int AW = mbbe_pkg::ADDR_W;
    localparam int CW = $clog2(RES_DEPTH + 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(mbbe_pkg::STORE_DEPTH - 1);

    logic [7:0]    r_mem [mbbe_pkg::STORE_DEPTH];
    logic [7:0]    r_rd;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_ph;
    logic [CW-1:0] r_credit;

    logic          r_b_valid;
    logic [1:0]    r_b_cmd;
    logic [AW-1:0] r_b_addr;
    logic [7:0]    r_b_mask;
    logic [7:0]    r_b_data;
    logic          r_b_color;
    logic          r_b_last;
    logic          r_b_done;
    logic          r_b_fwd;
    logic [7:0]    r_b_fwd_data;

    logic          last;
    logic          issue;
    logic [AW-1:0] sel_addr;
    logic [7:0]    sel_mask;
    logic [7:0]    old;
    logic [7:0]    b_wdata;
    logic          b_we;

    // pick the sub-update of the head item
    assign last     = !i_op.two || r_ph;
    assign sel_addr = r_ph ? i_op.addr1 : i_op.addr0;
    assign sel_mask = r_ph ? i_op.mask1 : i_op.mask0;
    assign issue    = !r_clr_busy && !i_op_empty && (!last || (r_credit != '0));
    assign o_op_pop = issue && last;
    assign o_busy   = r_clr_busy;

    // read-modify-write of one frame byte
    always_comb begin
        old     = r_b_fwd ? r_b_fwd_data : r_rd;
        b_wdata = old;
        b_we    = 1'b0;
        unique case (r_b_cmd) inside
            mbbe_pkg::CMD_BLIT: begin
                b_wdata = r_b_color ? (old | r_b_mask) : (old & ~r_b_mask);
                b_we    = r_b_valid && (r_b_mask != '0);
            end
            mbbe_pkg::CMD_WRITE: begin
                b_wdata = r_b_data;
                b_we    = r_b_valid;
            end
            mbbe_pkg::CMD_READ, mbbe_pkg::CMD_RESTART: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res_push      = r_b_valid && r_b_last;
    assign o_res.read_data = (r_b_cmd == mbbe_pkg::CMD_READ) ? old : 8'h00;
    assign o_res.blit_done = r_b_done;

    // control: clearing pass, phase, result credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_ph       <= 1'b0;
            r_credit   <= CW'(RES_DEPTH);
            r_b_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (issue) begin
                r_ph <= !last;
            end
            if (o_op_pop && !i_res_pop) begin
                r_credit <= r_credit - 1'b1;
            end else if (i_res_pop && !o_op_pop) begin
                r_credit <= r_credit + 1'b1;
            end
            r_b_valid <= issue;
        end
    end

    // update stage payload, with bypass of a write to the same byte
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_cmd      <= i_op.cmd;
            r_b_addr     <= sel_addr;
            r_b_mask     <= sel_mask;
            r_b_data     <= i_op.data;
            r_b_color    <= i_op.color;
            r_b_last     <= last;
            r_b_done     <= i_op.done;
            r_b_fwd      <= b_we && (r_b_addr == sel_addr);
            r_b_fwd_data <= b_wdata;
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd <= r_mem[sel_addr];
        end
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (b_we) begin
            r_mem[r_b_addr] <= b_wdata;
        end
    end

endmodule

### sv/mono_bitmap_blit_engine.sv
// an accepted item passes the front stage register, the op queue, the update
// stage and the result queue on its way to the output ports
// throughput: one item per cycle while full is low; a straddling bitmap byte is
// issued as two updates in turn, set by the single read-modify-write port
// reset: synchronous, active low; afterwards a clearing pass zeroes all 1024
// frame store bytes, during which full stays high
module mono_bitmap_blit_engine #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64,
    parameter int OPQ_DEPTH    = 4,
    parameter int RES_DEPTH    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic [9:0]  i_frame_address,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_data,
    output logic        o_blit_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    mbbe_pkg::t_cfg r_cfg;
    mbbe_pkg::t_op  op_in;
    mbbe_pkg::t_op  op_head;
    mbbe_pkg::t_res res_in;
    mbbe_pkg::t_res res_head;
    logic           op_push;
    logic           op_full;
    logic           op_empty;
    logic           op_pop;
    logic           res_push;
    logic           res_full;
    logic           res_pop;
    logic           back_busy;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x        <= 11'd0;
            r_cfg.dest_y        <= 11'd0;
            r_cfg.bitmap_width  <= 11'd8;
            r_cfg.bitmap_height <= 11'd8;
            r_cfg.draw_color    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbbe_pkg::REG_DEST_X:        r_cfg.dest_x        <= i_cfg_data;
                mbbe_pkg::REG_DEST_Y:        r_cfg.dest_y        <= i_cfg_data;
                mbbe_pkg::REG_BITMAP_WIDTH:  r_cfg.bitmap_width  <= i_cfg_data;
                mbbe_pkg::REG_BITMAP_HEIGHT: r_cfg.bitmap_height <= i_cfg_data;
                mbbe_pkg::REG_DRAW_COLOR:    r_cfg.draw_color    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // classify items and track bitmap position
    mbbe_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .i_frame_address (i_frame_address),
        .i_busy          (back_busy),
        .o_op_push       (op_push),
        .o_op            (op_in),
        .i_op_full       (op_full)
    );

    // queue between front and back
    mbbe_fifo #(
        .DEPTH (OPQ_DEPTH),
        .T     (mbbe_pkg::t_op)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_empty (op_empty),
        .o_data  (op_head)
    );

    // frame store updates
    mbbe_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op_head),
        .i_op_empty (op_empty),
        .o_op_pop   (op_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_pop  (res_pop),
        .o_busy     (back_busy)
    );

    // result queue
    assign res_pop = pop && !empty;

    mbbe_fifo #(
        .DEPTH (RES_DEPTH),
        .T     (mbbe_pkg::t_res)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (res_pop),
        .o_empty (empty),
        .o_data  (res_head)
    );

    assign o_read_data = res_head.read_data;
    assign o_blit_done = res_head.blit_done;

    // credits keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full result queue");

    a_op_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_push |-> !op_full)
        else $error("item pushed into full op queue");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_busy |-> full)
        else $error("input open during frame clearing");

    a_clear_no_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_busy |-> !res_push)
        else $error("result produced during frame clearing");

endmodule

### bench/tb_mono_bitmap_blit_engine.sv
`timescale 1ns / 1ps

module tb_mono_bitmap_blit_engine;

    localparam int FRAME_W = 128;
    localparam int FRAME_H = 64;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic        full;
    logic [1:0]  i_cmd           = mbbe_pkg::CMD_READ;
    logic [7:0]  i_data_byte     = 8'h00;
    logic [9:0]  i_frame_address = 10'd0;
    logic        empty;
    logic        pop             = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_blit_done;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index     = mbbe_pkg::REG_DEST_X;
    logic [10:0] i_cfg_data      = 11'd0;

    // image of the frame store, blit position and register copies
    logic [7:0]  frame_img [mbbe_pkg::STORE_DEPTH] = '{default: 8'h00};
    logic [9:0]  row_cnt   = 10'd0;
    logic [6:0]  col_cnt   = 7'd0;
    logic [10:0] cfg_dx    = 11'd0;
    logic [10:0] cfg_dy    = 11'd0;
    logic [10:0] cfg_w     = 11'd8;
    logic [10:0] cfg_h     = 11'd8;
    logic        cfg_color = 1'b1;

    mbbe_pkg::t_res results_due[$];
    mbbe_pkg::t_res next_result;
    int   fail_count = 0;
    int   gap_pct    = 25;
    int   stall_pct  = 25;
    int   stall_left = 0;

    mono_bitmap_blit_engine #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .i_frame_address (i_frame_address),
        .empty           (empty),
        .pop             (pop),
        .o_read_data     (o_read_data),
        .o_blit_done     (o_blit_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 100) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input int pct);
        if (int'($urandom_range(99)) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return int'($urandom_range(10, 40));
        end
        return int'($urandom_range(1, 3));
    endfunction

    // zero acts as one, above 1024 acts as 1024
    function automatic int eff_size(input logic [10:0] v);
        if (v == 11'd0) begin
            return 1;
        end
        if (v > 11'd1024) begin
            return 1024;
        end
        return int'(v);
    endfunction

    // frame update and expected result for one accepted item
    task automatic predict_item(input logic [1:0] cmd, input logic [7:0] data,
                                input logic [9:0] addr);
        int   w, h, bw, x0, py, px, col, idx;
        mbbe_pkg::t_res r;
        r = '0;
        case (cmd)
            mbbe_pkg::CMD_BLIT: begin
                w  = eff_size(cfg_w);
                h  = eff_size(cfg_h);
                bw = (w + 7) / 8;
                x0 = int'($signed(cfg_dx));
                py = int'($signed(cfg_dy)) + int'(row_cnt);
                for (int k = 0; k < 8; k++) begin
                    col = int'(col_cnt) * 8 + k;
                    px  = x0 + col;
                    if (col < w && data[7 - k] && px >= 0 && px < FRAME_W
                            && py >= 0 && py < FRAME_H) begin
                        idx = px / 8 + py * ((FRAME_W + 7) / 8);
                        if (idx < mbbe_pkg::STORE_DEPTH) begin
                            frame_img[idx][7 - (px % 8)] = cfg_color;
                        end
                    end
                end
                // row end when the column reaches or passes the byte width
                if (int'(col_cnt) + 1 >= bw) begin
                    col_cnt = 7'd0;
                    if (int'(row_cnt) + 1 >= h) begin
                        row_cnt     = 10'd0;
                        r.blit_done = 1'b1;
                    end else begin
                        row_cnt = row_cnt + 10'd1;
                    end
                end else begin
                    col_cnt = col_cnt + 7'd1;
                end
            end
            mbbe_pkg::CMD_READ: begin
                r.read_data = frame_img[addr];
            end
            mbbe_pkg::CMD_WRITE: begin
                frame_img[addr] = data;
            end
            default: begin
                row_cnt = 10'd0;
                col_cnt = 7'd0;
            end
        endcase
        results_due.push_back(r);
    endtask

    // push one item, holding push high across back-to-back items
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [9:0] addr);
        int gap;
        gap = pick_gap(gap_pct);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_cmd           <= cmd;
        i_data_byte     <= data;
        i_frame_address <= addr;
        do @(posedge i_clk); while (full);
        predict_item(cmd, data, addr);
    endtask

    task automatic send_random_item(input int blit_pct);
        int         sel;
        logic [1:0] cmd;
        logic [7:0] data;
        sel  = int'($urandom_range(99));
        data = 8'($urandom);
        if ($urandom_range(7) == 0) begin
            data = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        if (sel < blit_pct) begin
            cmd = mbbe_pkg::CMD_BLIT;
        end else if (sel < 98) begin
            cmd = $urandom_range(4) < 3 ? mbbe_pkg::CMD_READ : mbbe_pkg::CMD_WRITE;
        end else begin
            cmd = mbbe_pkg::CMD_RESTART;
        end
        send_item(cmd, data, 10'($urandom));
    endtask

    // stop sending until every expected result has been popped
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mbbe_pkg::REG_DEST_X:        cfg_dx    = val;
            mbbe_pkg::REG_DEST_Y:        cfg_dy    = val;
            mbbe_pkg::REG_BITMAP_WIDTH:  cfg_w     = val;
            mbbe_pkg::REG_BITMAP_HEIGHT: cfg_h     = val;
            mbbe_pkg::REG_DRAW_COLOR:    cfg_color = val[0];
            default: ;
        endcase
    endtask

    // registers are only written with the block idle
    task automatic set_config(input logic [10:0] dx, input logic [10:0] dy,
                              input logic [10:0] w, input logic [10:0] h,
                              input logic [10:0] color);
        drain_results();
        write_reg(mbbe_pkg::REG_DEST_X, dx);
        write_reg(mbbe_pkg::REG_DEST_Y, dy);
        write_reg(mbbe_pkg::REG_BITMAP_WIDTH, w);
        write_reg(mbbe_pkg::REG_BITMAP_HEIGHT, h);
        write_reg(mbbe_pkg::REG_DRAW_COLOR, color);
        i_cfg_valid <= 1'b0;
    endtask

    // direct store access at both ends of the address range
    task automatic test_store_access();
        send_item(mbbe_pkg::CMD_READ, 8'h00, 10'd0);
        send_item(mbbe_pkg::CMD_READ, 8'hFF, 10'd1023);
        send_item(mbbe_pkg::CMD_WRITE, 8'hFF, 10'd1023);
        send_item(mbbe_pkg::CMD_READ, 8'h00, 10'd1023);
    endtask

    // negative left edge straddling two frame bytes, bottom row then clipped row
    task automatic test_clipped_blit();
        set_config(11'(-3), 11'd63, 11'd16, 11'd2, 11'd1);
        send_item(mbbe_pkg::CMD_BLIT, 8'hFF, 10'd0);
        send_item(mbbe_pkg::CMD_BLIT, 8'h80, 10'd0);
        send_item(mbbe_pkg::CMD_READ, 8'h00, 10'd1008);
        send_item(mbbe_pkg::CMD_BLIT, 8'hFF, 10'd0);
        send_item(mbbe_pkg::CMD_BLIT, 8'h01, 10'd0);
    endtask

    // color zero clears pixels, right edge clipped
    task automatic test_clear_color();
        set_config(11'd125, 11'd0, 11'd8, 11'd1, 11'd0);
        send_item(mbbe_pkg::CMD_WRITE, 8'hFF, 10'd15);
        send_item(mbbe_pkg::CMD_BLIT, 8'hFF, 10'd0);
        send_item(mbbe_pkg::CMD_READ, 8'h00, 10'd15);
    endtask

    // zero width and height act as one pixel
    task automatic test_size_clamp();
        set_config(11'd5, 11'd0, 11'd0, 11'd0, 11'd1);
        send_item(mbbe_pkg::CMD_BLIT, 8'hFF, 10'd0);
        send_item(mbbe_pkg::CMD_READ, 8'h00, 10'd0);
    endtask

    // shrinking the bitmap mid-blit ends the row and the blit at once
    task automatic test_config_mid_blit();
        set_config(11'd0, 11'd10, 11'd32, 11'd4, 11'd1);
        repeat (6) send_item(mbbe_pkg::CMD_BLIT, 8'($urandom), 10'($urandom));
        set_config(11'd0, 11'd10, 11'd8, 11'd2, 11'd1);
        send_item(mbbe_pkg::CMD_BLIT, 8'hFF, 10'd0);
    endtask

    // oversize bitmap, restart, then a one-byte bitmap completes at once
    task automatic test_restart();
        set_config(11'd0, 11'd40, 11'd2047, 11'd1025, 11'd1);
        send_item(mbbe_pkg::CMD_BLIT, 8'hA5, 10'd0);
        send_item(mbbe_pkg::CMD_BLIT, 8'h5A, 10'd0);
        send_item(mbbe_pkg::CMD_RESTART, 8'hFF, 10'd1023);
        set_config(11'd0, 11'd40, 11'd8, 11'd1, 11'd1);
        send_item(mbbe_pkg::CMD_BLIT, 8'h3C, 10'd0);
    endtask

    // width above the maximum: 128 bytes per row
    task automatic test_wide_bitmap();
        set_config(11'(int'($urandom_range(0, 40)) - 20), 11'($urandom_range(0, 63)),
                   11'($urandom_range(1025, 2047)), 11'($urandom_range(0, 1)),
                   11'($urandom));
        send_item(mbbe_pkg::CMD_RESTART, 8'h00, 10'd0);
        repeat (140) send_random_item(95);
    endtask

    // phases of mixed traffic under changing settings and idling
    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                1, 8: begin
                    set_config(11'($urandom), 11'($urandom), 11'($urandom),
                               11'($urandom), 11'($urandom));
                end
                6: begin
                    set_config($urandom_range(1) ? 11'h400 : 11'h3FF,
                               $urandom_range(1) ? 11'h400 : 11'h3FF,
                               $urandom_range(1) ? 11'd1 : 11'd1024,
                               $urandom_range(1) ? 11'd1 : 11'd1024, 11'($urandom));
                end
                default: begin
                    set_config(11'(int'($urandom_range(0, 160)) - 16),
                               11'(int'($urandom_range(0, 80)) - 8),
                               11'($urandom_range(1, 24)), 11'($urandom_range(1, 10)),
                               11'($urandom));
                end
            endcase
            gap_pct   = (phase == 2) ? 0 : (phase == 5) ? 70 : 25;
            stall_pct = (phase == 2) ? 0 : (phase == 5) ? 70 : 25;
            if ($urandom_range(2) == 0) begin
                send_item(mbbe_pkg::CMD_RESTART, 8'($urandom), 10'($urandom));
            end
            for (int n = 0; n < 100; n++) begin
                if (phase == 3 && n == 50) begin
                    drain_results();
                end
                send_random_item(75);
            end
        end
        gap_pct   = 25;
        stall_pct = 25;
    endtask

    // result side: random stalls on pop
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            pop <= 1'b1;
            stall_left = pick_gap(stall_pct);
        end
    end

    // compare each popped result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && !empty && pop) begin
            if (results_due.size() == 0) begin
                report_mismatch("result popped with nothing expected");
            end else begin
                next_result = results_due.pop_front();
                if (o_read_data !== next_result.read_data) begin
                    report_mismatch($sformatf("read_data %02h, expected %02h",
                                              o_read_data, next_result.read_data));
                end
                if (o_blit_done !== next_result.blit_done) begin
                    report_mismatch($sformatf("blit_done %b, expected %b",
                                              o_blit_done, next_result.blit_done));
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_store_access();
        test_clipped_blit();
        test_clear_color();
        test_size_clamp();
        test_config_mid_blit();
        test_restart();
        test_random_traffic();
        test_wide_bitmap();
        drain_results();
        repeat (16) @(posedge i_clk);
        if (results_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
